@@ rtl/lts_pkg.sv @@
// Shared types, character constants and helper functions of the Lisp token scanner.
// No dependencies; used by every module under rtl/.
package lts_pkg;

    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_LBRACK     = 8'h5B;
    localparam logic [7:0] CH_RBRACK     = 8'h5D;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_BAR        = 8'h7C;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;

    localparam logic [2:0] CLS_SYMBOL    = 3'd0;
    localparam logic [2:0] CLS_KEYWORD   = 3'd1;
    localparam logic [2:0] CLS_STRING    = 3'd2;
    localparam logic [2:0] CLS_DECIMAL   = 3'd3;
    localparam logic [2:0] CLS_FLOAT     = 3'd4;
    localparam logic [2:0] CLS_SEPARATOR = 3'd5;

    typedef enum logic [2:0] {
        MODE_IDLE          = 3'd0,
        MODE_TOKEN         = 3'd1,
        MODE_STRING        = 3'd2,
        MODE_CLOSED        = 3'd3,
        MODE_LINE_COMMENT  = 3'd4,
        MODE_BLOCK_COMMENT = 3'd5
    } t_mode;

    typedef struct packed {
        logic [15:0] line;
        logic [2:0]  cls;
        logic        tok_last;
        logic        tok_first;
        logic [7:0]  ch;
    } t_rec;

    typedef struct packed {
        logic [1:0] cnt;
        t_rec       rec1;
        t_rec       rec0;
    } t_step;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) ||
               (c == CH_RBRACK) || (c == CH_LBRACE) || (c == CH_RBRACE);
    endfunction

    function automatic logic is_num_char(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic [2:0] token_class(input logic       quote_start,
                                               input logic [7:0] ch,
                                               input logic       numeric,
                                               input logic       period,
                                               input logic       is_first,
                                               input logic       colon_start);
        logic [2:0] cls;
        if (quote_start && (ch == CH_QUOTE)) begin
            cls = CLS_STRING;
        end else if (numeric) begin
            cls = period ? CLS_FLOAT : CLS_DECIMAL;
        end else if (is_first && is_bracket(ch)) begin
            cls = CLS_SEPARATOR;
        end else if (colon_start) begin
            cls = CLS_KEYWORD;
        end else begin
            cls = CLS_SYMBOL;
        end
        return cls;
    endfunction

endpackage

@@ rtl/lts_front.sv @@
// Front end of the Lisp token scanner: scan state, character classification and
// per-byte result records. Depends on lts_pkg.
module lts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_char,
    input  logic          i_line_end,
    input  logic [15:0]   i_line,
    input  logic          i_q_ready,
    output logic          o_push,
    output lts_pkg::t_step o_step
);

    lts_pkg::t_mode r_mode, n_mode, w_mode_a, m_mode;
    logic [7:0]  r_hc, n_hc, m_hc;
    logic        r_hv, n_hv, m_hv;
    logic        r_first, n_first, m_first;
    logic        r_sq, n_sq, m_sq;
    logic        r_sc, n_sc, m_sc;
    logic        r_num, n_num, m_num;
    logic        r_per, n_per, m_per;
    logic        r_bar, n_bar, w_bar_a;
    logic [15:0] r_line, n_line, m_line;

    logic        w_start, w_append, w_end, w_drop, w_sp, w_acc;
    logic        w_e0, w_e1;
    lts_pkg::t_rec w_rec_a, w_rec_b;

    assign w_acc = i_valid && i_q_ready;
    assign w_sp  = lts_pkg::is_space(i_char);

    always_comb begin
        w_start  = 1'b0;
        w_append = 1'b0;
        w_end    = 1'b0;
        w_drop   = 1'b0;
        w_mode_a = r_mode;
        w_bar_a  = r_bar;
        case (r_mode)
            lts_pkg::MODE_BLOCK_COMMENT: begin
                if (r_bar && (i_char == lts_pkg::CH_HASH)) begin
                    w_mode_a = lts_pkg::MODE_IDLE;
                    w_bar_a  = 1'b0;
                end else begin
                    w_bar_a = (i_char == lts_pkg::CH_BAR);
                end
            end
            lts_pkg::MODE_LINE_COMMENT: begin
            end
            lts_pkg::MODE_CLOSED: begin
                w_end    = 1'b1;
                w_mode_a = lts_pkg::MODE_IDLE;
                w_start  = !w_sp;
            end
            lts_pkg::MODE_STRING: begin
                w_append = 1'b1;
            end
            lts_pkg::MODE_TOKEN: begin
                if (w_sp) begin
                    w_end    = 1'b1;
                    w_mode_a = lts_pkg::MODE_IDLE;
                end else if (lts_pkg::is_bracket(i_char)) begin
                    w_end   = 1'b1;
                    w_start = 1'b1;
                end else if (r_hv && r_first && (r_hc == lts_pkg::CH_HASH) &&
                             (i_char == lts_pkg::CH_BAR)) begin
                    w_drop   = 1'b1;
                    w_mode_a = lts_pkg::MODE_BLOCK_COMMENT;
                    w_bar_a  = 1'b0;
                end else begin
                    w_append = 1'b1;
                end
            end
            default: begin
                w_mode_a = lts_pkg::MODE_IDLE;
                w_start  = !w_sp;
            end
        endcase
    end

    always_comb begin
        m_mode  = w_mode_a;
        m_hc    = r_hc;
        m_hv    = r_hv && !(w_drop || w_end);
        m_first = r_first;
        m_sq    = r_sq;
        m_sc    = r_sc;
        m_num   = r_num;
        m_per   = r_per;
        m_line  = r_line;
        if (w_append) begin
            m_hc    = i_char;
            m_first = 1'b0;
            m_hv    = 1'b1;
            if ((i_char == lts_pkg::CH_DOT) && !r_per) begin
                m_per = 1'b1;
            end else if (!lts_pkg::is_num_char(i_char)) begin
                m_num = 1'b0;
            end
            if ((w_mode_a == lts_pkg::MODE_STRING) && (i_char == lts_pkg::CH_QUOTE)) begin
                m_mode = lts_pkg::MODE_CLOSED;
            end
        end else if (w_start) begin
            if (i_char == lts_pkg::CH_SEMI) begin
                m_mode = lts_pkg::MODE_LINE_COMMENT;
            end else begin
                m_sq    = (i_char == lts_pkg::CH_QUOTE);
                m_sc    = (i_char == lts_pkg::CH_COLON);
                m_num   = lts_pkg::is_num_char(i_char) || (i_char == lts_pkg::CH_DOT);
                m_per   = (i_char == lts_pkg::CH_DOT);
                m_hc    = i_char;
                m_first = 1'b1;
                m_hv    = 1'b1;
                m_line  = i_line;
                if (lts_pkg::is_bracket(i_char)) begin
                    m_mode = lts_pkg::MODE_CLOSED;
                end else if (i_char == lts_pkg::CH_QUOTE) begin
                    m_mode = lts_pkg::MODE_STRING;
                end else begin
                    m_mode = lts_pkg::MODE_TOKEN;
                end
            end
        end

        n_mode  = m_mode;
        n_bar   = w_bar_a;
        n_hc    = m_hc;
        n_hv    = m_hv;
        n_first = m_first;
        n_sq    = m_sq;
        n_sc    = m_sc;
        n_num   = m_num;
        n_per   = m_per;
        n_line  = m_line;
        if (i_line_end) begin
            n_hv = 1'b0;
            if (m_mode == lts_pkg::MODE_BLOCK_COMMENT) begin
                n_bar = 1'b0;
            end else begin
                n_mode = lts_pkg::MODE_IDLE;
            end
        end
    end

    always_comb begin
        w_e0 = r_hv && !w_drop && (w_end || w_append);
        w_e1 = i_line_end && m_hv;

        w_rec_a.ch        = r_hc;
        w_rec_a.tok_first = r_first;
        w_rec_a.tok_last  = w_end;
        w_rec_a.cls       = w_end ? lts_pkg::token_class(r_sq, r_hc, r_num, r_per,
                                                         r_first, r_sc)
                                  : lts_pkg::CLS_SYMBOL;
        w_rec_a.line      = r_line;

        w_rec_b.ch        = m_hc;
        w_rec_b.tok_first = m_first;
        w_rec_b.tok_last  = 1'b1;
        w_rec_b.cls       = lts_pkg::token_class(m_sq, m_hc, m_num, m_per, m_first, m_sc);
        w_rec_b.line      = m_line;

        o_step.cnt  = {1'b0, w_e0} + {1'b0, w_e1};
        o_step.rec0 = w_e0 ? w_rec_a : w_rec_b;
        o_step.rec1 = w_rec_b;
        o_push      = w_acc && (w_e0 || w_e1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lts_pkg::MODE_IDLE;
            r_hc    <= 8'd0;
            r_hv    <= 1'b0;
            r_first <= 1'b0;
            r_sq    <= 1'b0;
            r_sc    <= 1'b0;
            r_num   <= 1'b1;
            r_per   <= 1'b0;
            r_bar   <= 1'b0;
            r_line  <= 16'd0;
        end else if (w_acc) begin
            r_mode  <= n_mode;
            r_hc    <= n_hc;
            r_hv    <= n_hv;
            r_first <= n_first;
            r_sq    <= n_sq;
            r_sc    <= n_sc;
            r_num   <= n_num;
            r_per   <= n_per;
            r_bar   <= n_bar;
            r_line  <= n_line;
        end
    end

endmodule

@@ rtl/lts_queue.sv @@
// Short register queue of per-byte result records between scanner front and back.
// Depends on lts_pkg.
module lts_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lts_pkg::t_step i_data,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output lts_pkg::t_step o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    lts_pkg::t_step r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_wr, w_rd;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/lts_back.sv @@
// Back end of the Lisp token scanner: output register that sends the one or two
// records of each byte as stream transactions. Depends on lts_pkg.
module lts_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  lts_pkg::t_step i_q_data,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output lts_pkg::t_rec  o_rec,
    output logic           o_run_last
);

    logic           r_valid;
    logic           r_idx;
    lts_pkg::t_step r_step;
    logic           w_load;

    assign o_valid    = r_valid;
    assign o_rec      = r_idx ? r_step.rec1 : r_step.rec0;
    assign o_run_last = r_idx || (r_step.cnt != 2'd2);
    assign w_load     = !r_valid || (i_ready && o_run_last);
    assign o_pop      = w_load && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
            r_idx   <= 1'b0;
        end else if (i_ready) begin
            r_idx <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_step <= i_q_data;
        end
    end

endmodule

@@ rtl/lisp_token_scanner.sv @@
// Lisp s-expression token scanner, top level: front end, record queue, back end.
// Depends on lts_pkg, lts_front, lts_queue and lts_back.
//
// Takes one source byte per clock and returns the bytes of each token one byte
// behind, with first/last marks and, on the last byte, the token class
// (symbol, keyword, string, decimal, float, separator). Comments and whitespace
// produce nothing. A byte that ends a line may produce two output transactions
// (the held byte and the byte itself); every other byte produces at most one,
// so the input runs at one byte per cycle while the output side keeps up, and
// slows only where the output port must send two transactions for one byte.
// The record queue of QUEUE_DEPTH entries lets the two sides stall apart.
module lisp_token_scanner #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] character, [23:8] src_line
    input  logic        s_axis_tlast,   // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] token_char, [23:8] token_line
    output logic [4:0]  m_axis_tuser,   // [0] token_first, [1] token_last, [4:2] token_class
    output logic        m_axis_tlast    // run_last
);

    logic           w_push, w_q_ready, w_q_valid, w_pop;
    lts_pkg::t_step w_step_in, w_step_out;
    lts_pkg::t_rec  w_rec;

    lts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_char     (s_axis_tdata[7:0]),
        .i_line_end (s_axis_tlast),
        .i_line     (s_axis_tdata[23:8]),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_step     (w_step_in)
    );

    lts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_step_in),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_step_out)
    );

    lts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_step_out),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_rec      (w_rec),
        .o_run_last (m_axis_tlast)
    );

    assign s_axis_tready = w_q_ready;
    assign m_axis_tdata  = {w_rec.line, w_rec.ch};
    assign m_axis_tuser  = {w_rec.cls, w_rec.tok_last, w_rec.tok_first};

endmodule
